[src/hjacobi_pkg.sv]
// Shared types, constants and arithmetic helpers of the Hermitian Jacobi eigensolver.
`timescale 1ns / 1ps
package hjacobi_pkg;

	localparam int MAX_ORDER_DEF = 8;
	localparam int WORD_BITS     = 32;
	localparam int CFG_W         = 32;

	// configuration register indexes
	localparam logic [1:0] CFG_ORDER   = 2'd0;
	localparam logic [1:0] CFG_VECTORS = 2'd1;
	localparam logic [1:0] CFG_CAP     = 2'd2;
	localparam logic [1:0] CFG_THRESH  = 2'd3;

	// register reset values
	localparam logic [3:0]  ORDER_RST  = 4'd8;
	localparam logic [3:0]  VECTOR_RST = 4'd8;
	localparam logic [15:0] CAP_RST    = 16'd1000;
	localparam logic [31:0] THRESH_RST = 32'd1;

	// rotation pass codes
	localparam logic [1:0] PASS_ROW = 2'd0;
	localparam logic [1:0] PASS_COL = 2'd1;
	localparam logic [1:0] PASS_VEC = 2'd2;

	localparam logic signed [WORD_BITS-1:0] Q30_ONE = 32'sh4000_0000;

	typedef struct packed {
		logic signed [WORD_BITS-1:0] re;
		logic signed [WORD_BITS-1:0] im;
	} cword_t;

	// round a Q2.30-scaled sum to nearest (half up) and saturate to one word
	function automatic logic signed [WORD_BITS-1:0] rnd_sat(input logic signed [65:0] s);
		logic signed [65:0] t;
		logic signed [35:0] q;
		t = s + 66'sd536870912;
		q = 36'(t >>> 30);
		if (q > 36'sd2147483647)
			return 32'sh7fff_ffff;
		else if (q < -36'sd2147483648)
			return 32'sh8000_0000;
		else
			return q[WORD_BITS-1:0];
	endfunction

endpackage

[src/hermitian_jacobi_eigensolver_core.sv]
// Top level: Hermitian Jacobi eigensolver built around two synchronous matrix memories.
`timescale 1ns / 1ps
// Loading takes one matrix element per cycle. After the last element the solve runs:
// an identity sweep over all DEPTH entries of the vector memory, then per rotation a
// search for the largest off-diagonal element, two square roots, a normalize, three
// divides and the row, column and vector rotation passes. Results then leave one at a
// time (n*n results), each held until the receiver takes it. Reset is asynchronous: config
// returns to defaults and the block waits for elements; the work memory is undefined.
module hermitian_jacobi_eigensolver_core
	import hjacobi_pkg::*;
#(
	parameter int MAX_ORDER = MAX_ORDER_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [1:0]                  cfg_index,
	input  logic [CFG_W-1:0]            cfg_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [2:0]                  row_index,
	input  logic [2:0]                  col_index,
	input  logic signed [31:0]          value_re,
	input  logic signed [31:0]          value_im,
	input  logic                        last_element,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [2:0]                  eigen_index,
	output logic [2:0]                  component_index,
	output logic signed [31:0]          eigenvalue,
	output logic signed [31:0]          vector_re,
	output logic signed [31:0]          vector_im,
	output logic                        converged,
	output logic                        last_result
);

	localparam int XW    = $clog2(MAX_ORDER);
	localparam int AW    = 2 * XW;
	localparam int DEPTH = 1 << AW;
	localparam int OW    = $clog2(MAX_ORDER + 1);

	localparam logic [4:0] S_LOAD  = 5'd0;
	localparam logic [4:0] S_INIT  = 5'd1;
	localparam logic [4:0] S_ITER  = 5'd2;
	localparam logic [4:0] S_SCAN  = 5'd3;
	localparam logic [4:0] S_DRAIN = 5'd4;
	localparam logic [4:0] S_DEC   = 5'd5;
	localparam logic [4:0] S_RD1   = 5'd6;
	localparam logic [4:0] S_RD2   = 5'd7;
	localparam logic [4:0] S_RD3   = 5'd8;
	localparam logic [4:0] S_RD4   = 5'd9;
	localparam logic [4:0] S_SQ1   = 5'd10;
	localparam logic [4:0] S_VEC   = 5'd11;
	localparam logic [4:0] S_NORM  = 5'd12;
	localparam logic [4:0] S_SQR   = 5'd13;
	localparam logic [4:0] S_SUM   = 5'd14;
	localparam logic [4:0] S_SQ2   = 5'd15;
	localparam logic [4:0] S_DIV   = 5'd16;
	localparam logic [4:0] S_P0    = 5'd17;
	localparam logic [4:0] S_P1    = 5'd18;
	localparam logic [4:0] S_P2    = 5'd19;
	localparam logic [4:0] S_P3    = 5'd20;
	localparam logic [4:0] S_E0    = 5'd21;
	localparam logic [4:0] S_E1    = 5'd22;
	localparam logic [4:0] S_E2    = 5'd23;

	logic [4:0]  state_q;

	// configuration
	logic [3:0]  ord_cfg_q;
	logic [3:0]  vw_q;
	logic [15:0] cap_q;
	logic [31:0] thr_q;

	logic [OW-1:0] ord;
	logic [XW-1:0] ord_m1;

	// control counters
	logic [15:0]   cnt_q;
	logic [AW-1:0] sw_q;
	logic [XW-1:0] si_q, ti_q, lo_q, hi_q, r_q, er_q, ec_q;
	logic [1:0]    pass_q;
	logic [1:0]    dv_q;
	logic [4:0]    dk_q;
	logic [4:0]    scnt_q;
	logic          conv_q;
	logic          v_s1, v_s2;
	logic          out_valid_q;

	// datapath
	logic [63:0]         thr2_q;
	logic [63:0]         best_q;
	logic [XW-1:0]       si_s1, ti_s1, si_s2, ti_s2;
	logic [63:0]         sqre_s2, sqim_s2;
	logic signed [32:0]  dd_q;
	cword_t              h_q;
	logic [31:0]         ad;
	logic [63:0]         ad2_q;
	logic [31:0]         root_q, nv_q;
	logic                neg_q [3];
	logic [33:0]         mag_q [3];
	logic [33:0]         m_q;
	logic [59:0]         sq_q [3];
	logic [63:0]         sx_q, sr_q, sb_q;
	logic [63:0]         sq_t, sr_nxt;
	logic                sq_ge;
	logic [32:0]         rem_q;
	logic [30:0]         quo_q;
	logic signed [31:0]  rot_q [3];
	cword_t              x_q, y_q;
	logic signed [63:0]  prod_q [8];

	// memories
	cword_t        wmem [0:DEPTH-1];
	cword_t        vmem [0:DEPTH-1];
	logic          w_we, v_we;
	logic [AW-1:0] w_wa, v_wa, w_ra_a, w_ra_b, v_ra_a, v_ra_b;
	cword_t        w_wd, v_wd, w_rd_a, w_rd_b, v_rd_a, v_rd_b;

	logic          in_ok;
	logic          in_acc;
	logic [AW-1:0] pa_addr, pb_addr;
	logic [63:0]   mg;
	logic          scan_last;

	// rotation arithmetic
	cword_t             px, py, rsel_a, rsel_b;
	logic signed [31:0] g1r, g1i, g2r, g2i;
	logic signed [65:0] sum_re, sum_im;
	cword_t             rot_wd;

	// divider step
	logic [32:0] dv_trial;
	logic        dv_ge;
	logic [30:0] quo_nxt;

	// normalize-stage candidate vector
	logic signed [34:0] vv [3];
	logic [33:0]        vmag [3];
	logic [33:0]        vmax;

	assign in_ready  = (state_q == S_LOAD);
	assign in_acc    = in_valid && in_ready;
	assign out_valid = out_valid_q;

	// order in use, clamped to the supported range
	always_comb begin
		if (ord_cfg_q < 4'd2)
			ord = OW'(2);
		else if (32'(ord_cfg_q) > MAX_ORDER)
			ord = OW'(MAX_ORDER);
		else
			ord = OW'(ord_cfg_q);
		ord_m1 = XW'(ord - OW'(1));
	end

	assign in_ok = (32'(row_index) < MAX_ORDER) && (32'(col_index) < MAX_ORDER);
	assign scan_last = (si_q == ord_m1 - XW'(1)) && (ti_q == ord_m1);

	// pass element addresses
	always_comb begin
		if (pass_q == PASS_ROW) begin
			pa_addr = {lo_q, r_q};
			pb_addr = {hi_q, r_q};
		end else begin
			pa_addr = {r_q, lo_q};
			pb_addr = {r_q, hi_q};
		end
	end

	// read address selection
	always_comb begin
		w_ra_a = '0;
		w_ra_b = '0;
		v_ra_a = '0;
		v_ra_b = '0;
		unique case (state_q)
			S_SCAN: w_ra_a = {si_q, ti_q};
			S_RD1: begin
				w_ra_a = {lo_q, lo_q};
				w_ra_b = {hi_q, hi_q};
			end
			S_RD2: w_ra_a = {lo_q, hi_q};
			S_P0: begin
				w_ra_a = pa_addr;
				w_ra_b = pb_addr;
				v_ra_a = pa_addr;
				v_ra_b = pb_addr;
			end
			S_E0: begin
				w_ra_a = {er_q, er_q};
				v_ra_a = {ec_q, er_q};
			end
			default: ;
		endcase
	end

	// rotation gains and products
	always_comb begin
		rsel_a = (pass_q == PASS_VEC) ? v_rd_a : w_rd_a;
		rsel_b = (pass_q == PASS_VEC) ? v_rd_b : w_rd_b;
		if (state_q == S_P1) begin
			px  = rsel_a;
			py  = rsel_b;
			g1r = rot_q[0];
			g1i = (pass_q == PASS_ROW) ? -rot_q[1] : rot_q[1];
			g2r = rot_q[2];
			g2i = '0;
		end else begin
			px  = x_q;
			py  = y_q;
			g1r = -rot_q[2];
			g1i = '0;
			g2r = rot_q[0];
			g2i = (pass_q == PASS_ROW) ? rot_q[1] : -rot_q[1];
		end
		sum_re = 66'(prod_q[0]) - 66'(prod_q[1]) + 66'(prod_q[2]) - 66'(prod_q[3]);
		sum_im = 66'(prod_q[4]) + 66'(prod_q[5]) + 66'(prod_q[6]) + 66'(prod_q[7]);
		rot_wd.re = rnd_sat(sum_re);
		rot_wd.im = rnd_sat(sum_im);
	end

	// write port selection
	always_comb begin
		w_we = 1'b0;
		w_wa = {XW'(row_index), XW'(col_index)};
		w_wd.re = value_re;
		w_wd.im = value_im;
		v_we = 1'b0;
		v_wa = sw_q;
		v_wd.re = (sw_q[AW-1:XW] == sw_q[XW-1:0]) ? Q30_ONE : '0;
		v_wd.im = '0;
		if (state_q == S_LOAD) begin
			w_we = in_acc && in_ok;
		end else if (state_q == S_INIT) begin
			v_we = 1'b1;
		end else if (state_q == S_P2 || state_q == S_P3) begin
			w_we = (pass_q != PASS_VEC);
			v_we = (pass_q == PASS_VEC);
			w_wa = (state_q == S_P2) ? pa_addr : pb_addr;
			v_wa = w_wa;
			w_wd = rot_wd;
			v_wd = rot_wd;
		end
	end

	// matrix memories, one write and two registered reads each
	always_ff @(posedge clk) begin
		if (w_we)
			wmem[w_wa] <= w_wd;
		w_rd_a <= wmem[w_ra_a];
		w_rd_b <= wmem[w_ra_b];
	end

	always_ff @(posedge clk) begin
		if (v_we)
			vmem[v_wa] <= v_wd;
		v_rd_a <= vmem[v_ra_a];
		v_rd_b <= vmem[v_ra_b];
	end

	// search magnitude and shared square-root step
	assign mg     = sqre_s2 + sqim_s2;
	assign sq_t   = sr_q + sb_q;
	assign sq_ge  = (sx_q >= sq_t);
	assign sr_nxt = sq_ge ? ((sr_q >> 1) + sb_q) : (sr_q >> 1);
	assign ad     = dd_q[32] ? 32'(-dd_q) : dd_q[31:0];

	// divider step: one quotient bit per cycle
	assign dv_trial = (dk_q == 5'd0) ? {3'b000, mag_q[dv_q][29:0]} : {rem_q[31:0], 1'b0};
	assign dv_ge    = (dv_trial >= {1'b0, nv_q});
	assign quo_nxt  = {quo_q[29:0], dv_ge};

	// eigenvector of the 2x2 block before normalizing
	always_comb begin
		vv[0] = {{2{h_q.re[31]}}, h_q.re, 1'b0};
		vv[1] = {{2{h_q.im[31]}}, h_q.im, 1'b0};
		vv[2] = $signed({2'b00, root_q, 1'b0}) - $signed({{2{dd_q[32]}}, dd_q});
		for (int k = 0; k < 3; k++)
			vmag[k] = vv[k][34] ? 34'(-vv[k]) : vv[k][33:0];
		vmax = vmag[0];
		if (vmag[1] > vmax) vmax = vmag[1];
		if (vmag[2] > vmax) vmax = vmag[2];
	end

	// sequencer and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			ord_cfg_q   <= ORDER_RST;
			vw_q        <= VECTOR_RST;
			cap_q       <= CAP_RST;
			thr_q       <= THRESH_RST;
			cnt_q       <= '0;
			sw_q        <= '0;
			si_q        <= '0;
			ti_q        <= '0;
			lo_q        <= '0;
			hi_q        <= '0;
			r_q         <= '0;
			er_q        <= '0;
			ec_q        <= '0;
			pass_q      <= PASS_ROW;
			dv_q        <= '0;
			dk_q        <= '0;
			scnt_q      <= '0;
			conv_q      <= 1'b0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_ORDER:   ord_cfg_q <= cfg_data[3:0];
					CFG_VECTORS: vw_q      <= cfg_data[3:0];
					CFG_CAP:     cap_q     <= cfg_data[15:0];
					CFG_THRESH:  thr_q     <= cfg_data[31:0];
				endcase
			end

			v_s1 <= (state_q == S_SCAN);
			v_s2 <= v_s1;

			// track the largest off-diagonal magnitude
			if (v_s2 && mg > best_q) begin
				lo_q <= si_s2;
				hi_q <= ti_s2;
			end

			unique case (state_q)
				S_LOAD: begin
					if (in_acc && last_element) begin
						sw_q    <= '0;
						cnt_q   <= '0;
						conv_q  <= 1'b0;
						state_q <= S_INIT;
					end
				end
				S_INIT: begin
					sw_q <= sw_q + AW'(1);
					if (sw_q == AW'(DEPTH - 1))
						state_q <= S_ITER;
				end
				S_ITER: begin
					if (cnt_q >= cap_q) begin
						er_q    <= '0;
						ec_q    <= '0;
						state_q <= S_E0;
					end else begin
						cnt_q   <= cnt_q + 16'd1;
						si_q    <= '0;
						ti_q    <= XW'(1);
						lo_q    <= '0;
						hi_q    <= XW'(1);
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (scan_last) begin
						state_q <= S_DRAIN;
					end else if (ti_q == ord_m1) begin
						si_q <= si_q + XW'(1);
						ti_q <= si_q + XW'(2);
					end else begin
						ti_q <= ti_q + XW'(1);
					end
				end
				S_DRAIN: begin
					if (!v_s1 && !v_s2)
						state_q <= S_DEC;
				end
				S_DEC: begin
					if (best_q < thr2_q) begin
						conv_q  <= 1'b1;
						er_q    <= '0;
						ec_q    <= '0;
						state_q <= S_E0;
					end else begin
						state_q <= S_RD1;
					end
				end
				S_RD1: state_q <= S_RD2;
				S_RD2: state_q <= S_RD3;
				S_RD3: state_q <= S_RD4;
				S_RD4: begin
					scnt_q  <= '0;
					state_q <= S_SQ1;
				end
				S_SQ1: begin
					scnt_q <= scnt_q + 5'd1;
					if (scnt_q == 5'd31)
						state_q <= S_VEC;
				end
				S_VEC: begin
					if (vmax == '0) begin
						er_q    <= '0;
						ec_q    <= '0;
						state_q <= S_E0;
					end else begin
						state_q <= S_NORM;
					end
				end
				S_NORM: begin
					if (m_q < 34'h0_4000_0000 && m_q >= 34'h0_2000_0000)
						state_q <= S_SQR;
				end
				S_SQR: state_q <= S_SUM;
				S_SUM: begin
					scnt_q  <= '0;
					state_q <= S_SQ2;
				end
				S_SQ2: begin
					scnt_q <= scnt_q + 5'd1;
					if (scnt_q == 5'd31) begin
						dv_q    <= '0;
						dk_q    <= '0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (dk_q == 5'd30) begin
						dk_q <= '0;
						dv_q <= dv_q + 2'd1;
						if (dv_q == 2'd2) begin
							r_q     <= '0;
							pass_q  <= PASS_ROW;
							state_q <= S_P0;
						end
					end else begin
						dk_q <= dk_q + 5'd1;
					end
				end
				S_P0: state_q <= S_P1;
				S_P1: state_q <= S_P2;
				S_P2: state_q <= S_P3;
				S_P3: begin
					state_q <= S_P0;
					if (r_q == ord_m1) begin
						r_q <= '0;
						if (pass_q == PASS_VEC)
							state_q <= S_ITER;
						else
							pass_q <= pass_q + 2'd1;
					end else begin
						r_q <= r_q + XW'(1);
					end
				end
				S_E0: state_q <= S_E1;
				S_E1: begin
					out_valid_q <= 1'b1;
					state_q     <= S_E2;
				end
				S_E2: begin
					if (out_ready) begin
						out_valid_q <= 1'b0;
						state_q     <= S_E0;
						if (ec_q == ord_m1) begin
							ec_q <= '0;
							if (er_q == ord_m1)
								state_q <= S_LOAD;
							else
								er_q <= er_q + XW'(1);
						end else begin
							ec_q <= ec_q + XW'(1);
						end
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		// search pipeline
		si_s1   <= si_q;
		ti_s1   <= ti_q;
		si_s2   <= si_s1;
		ti_s2   <= ti_s1;
		sqre_s2 <= 64'($signed(w_rd_a.re) * $signed(w_rd_a.re));
		sqim_s2 <= 64'($signed(w_rd_a.im) * $signed(w_rd_a.im));
		if (state_q == S_ITER)
			best_q <= '0;
		else if (v_s2 && mg > best_q)
			best_q <= mg;

		if (state_q == S_INIT)
			thr2_q <= 64'(thr_q) * 64'(thr_q);

		// 2x2 block setup
		if (state_q == S_RD2)
			dd_q <= 33'($signed(w_rd_a.re)) - 33'($signed(w_rd_b.re));
		if (state_q == S_RD3) begin
			h_q   <= w_rd_a;
			ad2_q <= 64'(ad) * 64'(ad);
		end

		// shared square root, two radicand bits per step
		if (state_q == S_RD4 || state_q == S_SUM) begin
			sx_q <= (state_q == S_RD4) ? ((ad2_q >> 2) + best_q) :
				(64'(sq_q[0]) + 64'(sq_q[1]) + 64'(sq_q[2]));
			sr_q <= '0;
			sb_q <= 64'h4000_0000_0000_0000;
		end else if (state_q == S_SQ1 || state_q == S_SQ2) begin
			if (sq_ge)
				sx_q <= sx_q - sq_t;
			sr_q <= sr_nxt;
			sb_q <= sb_q >> 2;
			if (scnt_q == 5'd31) begin
				if (state_q == S_SQ1)
					root_q <= sr_nxt[31:0];
				else
					nv_q <= sr_nxt[31:0];
			end
		end

		// magnitudes and normalize shifts
		if (state_q == S_VEC) begin
			for (int k = 0; k < 3; k++) begin
				neg_q[k] <= vv[k][34];
				mag_q[k] <= vmag[k];
			end
			m_q <= vmax;
		end else if (state_q == S_NORM) begin
			if (m_q >= 34'h0_4000_0000) begin
				for (int k = 0; k < 3; k++)
					mag_q[k] <= mag_q[k] >> 1;
				m_q <= m_q >> 1;
			end else if (m_q < 34'h0_2000_0000) begin
				for (int k = 0; k < 3; k++)
					mag_q[k] <= mag_q[k] << 1;
				m_q <= m_q << 1;
			end
		end

		if (state_q == S_SQR) begin
			for (int k = 0; k < 3; k++)
				sq_q[k] <= mag_q[k][29:0] * mag_q[k][29:0];
		end

		// restoring divide of each component by the norm
		if (state_q == S_DIV) begin
			rem_q <= dv_ge ? (dv_trial - {1'b0, nv_q}) : dv_trial;
			if (dk_q == 5'd30) begin
				quo_q <= '0;
				rot_q[dv_q] <= neg_q[dv_q] ? -$signed({1'b0, quo_nxt}) : $signed({1'b0, quo_nxt});
			end else begin
				quo_q <= quo_nxt;
			end
		end

		// rotation pass operands and products
		if (state_q == S_P1) begin
			x_q <= rsel_a;
			y_q <= rsel_b;
		end
		if (state_q == S_P1 || state_q == S_P2) begin
			prod_q[0] <= $signed(px.re) * g1r;
			prod_q[1] <= $signed(px.im) * g1i;
			prod_q[2] <= $signed(py.re) * g2r;
			prod_q[3] <= $signed(py.im) * g2i;
			prod_q[4] <= $signed(px.re) * g1i;
			prod_q[5] <= $signed(px.im) * g1r;
			prod_q[6] <= $signed(py.re) * g2i;
			prod_q[7] <= $signed(py.im) * g2r;
		end

		// result register
		if (state_q == S_E1) begin
			eigen_index     <= 3'(er_q);
			component_index <= 3'(ec_q);
			eigenvalue      <= w_rd_a.re;
			if ({1'b0, er_q} < {1'b0, vw_q}) begin
				vector_re <= v_rd_a.re;
				vector_im <= v_rd_a.im;
			end else begin
				vector_re <= '0;
				vector_im <= '0;
			end
			converged   <= conv_q;
			last_result <= (er_q == ord_m1) && (ec_q == ord_m1);
		end
	end

endmodule

[tb/sv/hjacobi_checker.sv]
// Checker for the Hermitian Jacobi eigensolver: predicts every eigenpair item and compares.
`timescale 1ns / 1ps
module hjacobi_checker
	import hjacobi_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [CFG_W-1:0]   cfg_data,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [2:0]         row_index,
	input  logic [2:0]         col_index,
	input  logic signed [31:0] value_re,
	input  logic signed [31:0] value_im,
	input  logic               last_element,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic [2:0]         eigen_index,
	input  logic [2:0]         component_index,
	input  logic signed [31:0] eigenvalue,
	input  logic signed [31:0] vector_re,
	input  logic signed [31:0] vector_im,
	input  logic               converged,
	input  logic               last_result,
	output int                 fail_count,
	output int                 pending
);

	typedef struct {
		int re;
		int im;
	} cx_t;

	typedef struct {
		logic [2:0]  eig;
		logic [2:0]  comp;
		logic [31:0] eval;
		logic [31:0] vre;
		logic [31:0] vim;
		logic        conv;
		logic        last;
	} eigpair_t;

	localparam longint ONE_Q30 = 64'sd1073741824;

	cx_t         mat[8][8];
	cx_t         evec[8][8];
	logic [3:0]  order_q;
	logic [3:0]  vw_q;
	logic [15:0] cap_q;
	logic [31:0] thr_q;
	eigpair_t    eigpair_q[$];

	// exact floor square root
	function automatic longint unsigned root64(input longint unsigned x);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'h4000_0000_0000_0000;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic longint unsigned mag_sq(input cx_t v);
		longint a;
		longint b;
		a = v.re;
		b = v.im;
		return longint'(a * a) + longint'(b * b);
	endfunction

	function automatic int word_sat(input longint v);
		if (v > 64'sd2147483647) return 32'h7fff_ffff;
		if (v < -64'sd2147483648) return 32'h8000_0000;
		return int'(v);
	endfunction

	// x*g1 + y*g2, Q2.30 coefficients, round half up then saturate
	function automatic cx_t mix(input cx_t x, input longint g1r, input longint g1i,
			input cx_t y, input longint g2r, input longint g2i);
		longint sr;
		longint si;
		cx_t o;
		sr = longint'(x.re) * g1r - longint'(x.im) * g1i
			+ longint'(y.re) * g2r - longint'(y.im) * g2i;
		si = longint'(x.re) * g1i + longint'(x.im) * g1r
			+ longint'(y.re) * g2i + longint'(y.im) * g2r;
		o.re = word_sat((sr + 64'sd536870912) >>> 30);
		o.im = word_sat((si + 64'sd536870912) >>> 30);
		return o;
	endfunction

	// one complex Givens rotation on pair (lo, hi); 0 on a degenerate block
	function automatic bit givens(input int n, input int lo, input int hi);
		cx_t h;
		cx_t x;
		cx_t y;
		longint dd;
		longint unsigned ad;
		longint root;
		longint v[3];
		longint cr;
		longint ci;
		longint qv;
		longint unsigned m;
		longint unsigned a;
		longint unsigned nsq;
		longint unsigned nv;
		int sr;
		int sl;
		bit neg;
		h = mat[lo][hi];
		dd = longint'(mat[lo][lo].re) - longint'(mat[hi][hi].re);
		ad = (dd < 0) ? -dd : dd;
		root = root64(((ad * ad) >> 2) + mag_sq(h));
		v[0] = 2 * longint'(h.re);
		v[1] = 2 * longint'(h.im);
		v[2] = 2 * root - dd;
		m = 0;
		for (int k = 0; k < 3; k++) begin
			a = (v[k] < 0) ? -v[k] : v[k];
			if (a > m) m = a;
		end
		if (m == 0) return 0;
		sr = 0;
		sl = 0;
		while (m >= 64'd1073741824) begin m = m >> 1; sr++; end
		while (m < 64'd536870912) begin m = m << 1; sl++; end
		nsq = 0;
		for (int k = 0; k < 3; k++) begin
			neg = v[k] < 0;
			a = neg ? -v[k] : v[k];
			a = (a >> sr) << sl;
			v[k] = neg ? -longint'(a) : longint'(a);
			nsq = nsq + longint'(v[k] * v[k]);
		end
		nv = root64(nsq);
		cr = v[0] * ONE_Q30 / longint'(nv);
		ci = v[1] * ONE_Q30 / longint'(nv);
		qv = v[2] * ONE_Q30 / longint'(nv);
		for (int k = 0; k < n; k++) begin
			x = mat[lo][k];
			y = mat[hi][k];
			mat[lo][k] = mix(x, cr, -ci, y, qv, 0);
			mat[hi][k] = mix(x, -qv, 0, y, cr, ci);
		end
		for (int k = 0; k < n; k++) begin
			x = mat[k][lo];
			y = mat[k][hi];
			mat[k][lo] = mix(x, cr, ci, y, qv, 0);
			mat[k][hi] = mix(x, -qv, 0, y, cr, -ci);
			x = evec[k][lo];
			y = evec[k][hi];
			evec[k][lo] = mix(x, cr, ci, y, qv, 0);
			evec[k][hi] = mix(x, -qv, 0, y, cr, -ci);
		end
		return 1;
	endfunction

	// classical Jacobi sweep; returns the converged flag
	function automatic bit jacobi_solve(input int n);
		longint unsigned thr2;
		longint unsigned best;
		longint unsigned mg;
		int cnt;
		int lo;
		int hi;
		thr2 = longint'(thr_q) * longint'(thr_q);
		for (int r = 0; r < 8; r++)
			for (int t = 0; t < 8; t++) begin
				evec[r][t].re = (r == t) ? 32'h4000_0000 : 0;
				evec[r][t].im = 0;
			end
		cnt = 0;
		while (cnt < int'(cap_q)) begin
			lo = 0;
			hi = 1;
			best = 0;
			cnt++;
			for (int r = 0; r < n; r++)
				for (int t = r + 1; t < n; t++) begin
					mg = mag_sq(mat[r][t]);
					if (mg > best) begin
						best = mg;
						lo = r;
						hi = t;
					end
				end
			if (best < thr2) return 1;
			if (!givens(n, lo, hi)) return 0;
		end
		return 0;
	endfunction

	// build the eigenpair items of one solve
	task automatic predict_eigenpairs();
		int n;
		bit conv;
		eigpair_t e;
		n = order_q;
		if (n < 2) n = 2;
		if (n > 8) n = 8;
		conv = jacobi_solve(n);
		for (int r = 0; r < n; r++)
			for (int t = 0; t < n; t++) begin
				e.eig  = r[2:0];
				e.comp = t[2:0];
				e.eval = mat[r][r].re;
				e.vre  = (r < vw_q) ? evec[t][r].re : 0;
				e.vim  = (r < vw_q) ? evec[t][r].im : 0;
				e.conv = conv;
				e.last = (r == n - 1) && (t == n - 1);
				eigpair_q.push_back(e);
			end
	endtask

	// watch both channels and the register port
	always @(posedge clk or negedge arst_n) begin
		eigpair_t e;
		if (!arst_n) begin
			order_q = ORDER_RST;
			vw_q = VECTOR_RST;
			cap_q = CAP_RST;
			thr_q = THRESH_RST;
			eigpair_q.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_ORDER:   order_q = cfg_data[3:0];
					CFG_VECTORS: vw_q = cfg_data[3:0];
					CFG_CAP:     cap_q = cfg_data[15:0];
					CFG_THRESH:  thr_q = cfg_data;
				endcase
			end
			if (out_valid && out_ready) begin
				if (eigpair_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("ERROR: unexpected item eig=%0d comp=%0d",
							eigen_index, component_index);
				end else begin
					e = eigpair_q.pop_front();
					if (eigen_index !== e.eig || component_index !== e.comp ||
							eigenvalue !== e.eval || vector_re !== e.vre ||
							vector_im !== e.vim || converged !== e.conv ||
							last_result !== e.last) begin
						fail_count++;
						if (fail_count <= 10)
							$display({"ERROR: exp eig=%0d comp=%0d val=%h vec=%h/%h cv=%b ",
								"ls=%b got eig=%0d comp=%0d val=%h vec=%h/%h cv=%b ls=%b"},
								e.eig, e.comp, e.eval, e.vre, e.vim, e.conv, e.last,
								eigen_index, component_index, eigenvalue, vector_re,
								vector_im, converged, last_result);
					end
				end
			end
			if (in_valid && in_ready) begin
				mat[row_index][col_index].re = value_re;
				mat[row_index][col_index].im = value_im;
				if (last_element) predict_eigenpairs();
			end
			pending = eigpair_q.size();
		end
	end

endmodule

[tb/sv/tb_hermitian_jacobi_eigensolver_core.sv]
// Testbench top: clock, reset, register setup, matrix stimulus and verdict.
`timescale 1ns / 1ps
module tb_hermitian_jacobi_eigensolver_core;
	import hjacobi_pkg::*;

	localparam int IDLE_LIMIT = 300000;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [1:0]         cfg_index;
	logic [CFG_W-1:0]   cfg_data;
	logic               in_valid;
	logic               in_ready;
	logic [2:0]         row_index;
	logic [2:0]         col_index;
	logic signed [31:0] value_re;
	logic signed [31:0] value_im;
	logic               last_element;
	logic               out_valid;
	logic               out_ready;
	logic [2:0]         eigen_index;
	logic [2:0]         component_index;
	logic signed [31:0] eigenvalue;
	logic signed [31:0] vector_re;
	logic signed [31:0] vector_im;
	logic               converged;
	logic               last_result;
	int                 fail_count;
	int                 pending;

	int  items_sent;
	int  burst_left;
	bit  hold_req;
	bit  hold_done;

	hermitian_jacobi_eigensolver_core dut (.*);

	hjacobi_checker u_checker (.*);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	// watchdog on cycles with no item moving
	initial begin
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready)) idle = 0;
			else idle++;
		end
		$display("FAIL hermitian_jacobi_eigensolver_core");
		$finish;
	end

	// receiver: random stall modes, plus one long hold-off
	initial begin
		int mode;
		int left;
		out_ready = 0;
		mode = 0;
		left = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done && out_valid) begin
				out_ready <= 0;
				repeat (3000) @(negedge clk);
				hold_done = 1;
			end else begin
				if (left == 0) begin
					mode = $urandom_range(0, 2);
					left = $urandom_range(16, 96);
				end
				left--;
				case (mode)
					0: out_ready <= 1;
					1: out_ready <= $urandom_range(0, 1);
					default: out_ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	task automatic send_element(input int r, input int c, input int re, input int im,
			input bit last);
		int gap;
		@(negedge clk);
		in_valid <= 1;
		row_index <= r[2:0];
		col_index <= c[2:0];
		value_re <= re;
		value_im <= im;
		last_element <= last;
		do @(posedge clk); while (!in_ready);
		items_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				@(negedge clk);
				in_valid <= 0;
				repeat (gap - 1) @(negedge clk);
			end
		end
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
		@(negedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 0;
	endtask

	// registers change only once all eigenpairs are out
	task automatic set_config(input int order, input int vw, input int cap, input int thr);
		@(negedge clk);
		in_valid <= 0;
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		write_reg(CFG_ORDER, order);
		write_reg(CFG_VECTORS, vw);
		write_reg(CFG_CAP, cap);
		write_reg(CFG_THRESH, thr);
	endtask

	function automatic int elem_value(input int style);
		case (style)
			1: return $urandom;
			2: case ($urandom_range(0, 3))
				0: return 32'h7fff_ffff;
				1: return 32'h8000_0000;
				2: return 0;
				default: return -1;
			endcase
			4: return 0;
			default: return int'($urandom_range(0, 1048576)) - 524288;
		endcase
	endfunction

	// style: 0 small, 1 full range, 2 extremes, 3 non-Hermitian, 4 all zero
	task automatic load_matrix(input int order, input int style);
		int n;
		int are[8][8];
		int aim[8][8];
		int pos[64];
		int j;
		int tmp;
		n = (order < 2) ? 2 : (order > 8) ? 8 : order;
		for (int r = 0; r < n; r++)
			for (int c = r; c < n; c++) begin
				are[r][c] = elem_value(style);
				aim[r][c] = (r == c && style != 3) ? 0 : elem_value(style);
				are[c][r] = (style == 3) ? elem_value(style) : are[r][c];
				aim[c][r] = (style == 3) ? elem_value(style) : -aim[r][c];
			end
		// some writes outside the block in use
		if (n < 8 && $urandom_range(0, 2) == 0)
			repeat ($urandom_range(1, 3))
				send_element($urandom_range(n, 7), $urandom_range(0, 7), $urandom, $urandom, 0);
		for (int k = 0; k < n * n; k++) pos[k] = k;
		for (int k = n * n - 1; k > 0; k--) begin
			j = $urandom_range(0, k);
			tmp = pos[k];
			pos[k] = pos[j];
			pos[j] = tmp;
		end
		for (int k = 0; k < n * n; k++)
			send_element(pos[k] / n, pos[k] % n, are[pos[k] / n][pos[k] % n],
				aim[pos[k] / n][pos[k] % n], k == n * n - 1);
	endtask

	function automatic int pick_threshold();
		case ($urandom_range(0, 4))
			0: return 0;
			1: return $urandom_range(1, 64);
			2: return $urandom_range(256, 65536);
			3: return $urandom;
			default: return $urandom_range(1024, 8192);
		endcase
	endfunction

	// main stimulus
	initial begin
		int order;
		arst_n = 0;
		cfg_we = 0;
		cfg_index = CFG_ORDER;
		cfg_data = 0;
		in_valid = 0;
		row_index = 0;
		col_index = 0;
		value_re = 0;
		value_im = 0;
		last_element = 0;
		items_sent = 0;
		burst_left = 0;
		hold_req = 0;
		hold_done = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// extremes of the element values, single rotation
		set_config(2, 2, 1, 0);
		load_matrix(2, 2);
		// order below range, no vectors, converges at once with widest cap
		set_config(0, 0, 65535, 32'hffff_ffff);
		load_matrix(2, 0);
		// degenerate all-zero block with zero threshold
		set_config(1, 1, 10, 0);
		load_matrix(2, 4);
		// vectors beyond order; back-to-back solves under a long receiver stall
		set_config(3, 15, 20, 1024);
		hold_req = 1;
		load_matrix(3, 0);
		load_matrix(3, 1);
		// order above range clamps to the largest block
		set_config(15, 8, 6, 0);
		load_matrix(15, 0);

		while (items_sent < 210) begin
			if ($urandom_range(0, 1) == 0) begin
				order = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 8)
					: $urandom_range(2, 4);
				set_config(order, $urandom_range(0, 8), $urandom_range(1, 30),
					pick_threshold());
			end
			load_matrix(order, ($urandom_range(0, 5) == 0) ? 1
				: ($urandom_range(0, 5) == 0) ? 3 : 0);
		end

		@(negedge clk);
		in_valid <= 0;
		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (fail_count == 0)
			$display("PASS hermitian_jacobi_eigensolver_core");
		else
			$display("FAIL hermitian_jacobi_eigensolver_core");
		$finish;
	end

endmodule

[files.f]
src/hjacobi_pkg.sv
src/hermitian_jacobi_eigensolver_core.sv
tb/sv/hjacobi_checker.sv
tb/sv/tb_hermitian_jacobi_eigensolver_core.sv
